>>> sv/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, register map and helpers for the string compare block.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  localparam int BYTE_W    = 8;
  localparam int PAT_BYTES = 16;
  localparam int PAT_W     = PAT_BYTES * BYTE_W;
  localparam int LEN_W     = 5;
  localparam int POS_W     = 5;
  localparam int MODE_W    = 2;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 5;

  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  // mode bits
  localparam int MODE_INVERT_BIT   = 0;
  localparam int MODE_CONTAINS_BIT = 1;

  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_PATTERN_LEN  = 2'd1,
    REG_PATTERN_LOW  = 2'd2,
    REG_PATTERN_HIGH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  pattern_len;
    logic [PAT_W-1:0]  pattern;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] char_byte;
    logic              is_last;
    logic              is_empty;
  } item_t;

  function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                 input logic [3:0] k);
    pat_byte = pat[{k, 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

>>> sv/scm_regs.sv
// ----------------------------------------------------------------------------
// scm_regs
// Configuration register file on an APB-style port with a 64-bit data bus.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_regs
  import scm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [MODE_W-1:0] mode_r;
  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] pat_lo_r;
  logic [DATA_W-1:0] pat_hi_r;
  reg_idx_t          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      len_r    <= '0;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:         mode_r   <= pwdata[MODE_W-1:0];
        REG_PATTERN_LEN:  len_r    <= pwdata[LEN_W-1:0];
        REG_PATTERN_LOW:  pat_lo_r <= pwdata;
        REG_PATTERN_HIGH: pat_hi_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:         prdata = {{(DATA_W-MODE_W){1'b0}}, mode_r};
      REG_PATTERN_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, len_r};
      REG_PATTERN_LOW:  prdata = pat_lo_r;
      REG_PATTERN_HIGH: prdata = pat_hi_r;
      default:          prdata = '0;
    endcase
  end

  assign cfg.mode        = mode_r;
  assign cfg.pattern_len = len_r;
  assign cfg.pattern     = {pat_hi_r, pat_lo_r};

endmodule

`default_nettype wire

>>> sv/scm_core.sv
// ----------------------------------------------------------------------------
// scm_core
// Per-string compare state, window compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_core
  import scm_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  s1_valid,
  input  wire item_t s1_item,
  output logic       take,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_match
);

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W:0]   WIN_SIZE = (LEN_W + 1)'(MAX_PATTERN);

  logic [BYTE_W-1:0] window_r [MAX_PATTERN];
  logic [BYTE_W-1:0] win_new  [MAX_PATTERN];
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_take;
  logic              eq_r, eq_nxt, eq_take;
  logic              found_r, found_nxt, found_take;
  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r, out_match_nxt;
  logic [LEN_W-1:0]  len;
  logic              hit;
  logic              res;
  logic [LEN_W:0]    sum;
  logic [LEN_W:0]    k;

  // lengths beyond the window are clipped to it
  assign len  = (cfg.pattern_len > MAX_LEN) ? MAX_LEN : cfg.pattern_len;
  // a non-last item never waits on the result register
  assign take = s1_valid & (~s1_item.is_last | ~out_valid_r | out_ready);

  always_comb begin
    for (int j = 0; j < MAX_PATTERN - 1; j++) begin
      win_new[j] = window_r[j+1];
    end
    win_new[MAX_PATTERN-1] = s1_item.char_byte;
  end

  // pattern aligned to the newest end of the window
  always_comb begin
    hit = 1'b1;
    sum = '0;
    k   = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      sum = (LEN_W + 1)'(j) + {1'b0, len};
      k   = sum - WIN_SIZE;
      if (sum >= WIN_SIZE && win_new[j] != pat_byte(cfg.pattern, k[3:0])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    pos_take   = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    eq_take    = eq_r && (pos_r < len) &&
                 (s1_item.char_byte == pat_byte(cfg.pattern, pos_r[3:0]));
    found_take = found_r || ((pos_take >= len) && hit);

    if (s1_item.is_empty) begin
      pos_nxt   = pos_r;
      eq_nxt    = eq_r;
      found_nxt = found_r;
    end else begin
      pos_nxt   = pos_take;
      eq_nxt    = eq_take;
      found_nxt = found_take;
    end

    if (cfg.mode[MODE_CONTAINS_BIT]) begin
      res = (len == '0) || found_nxt;
    end else begin
      res = (eq_nxt && (pos_nxt == len)) ^ cfg.mode[MODE_INVERT_BIT];
    end

    out_valid_nxt = out_valid_r & ~out_ready;
    out_match_nxt = out_match_r;
    if (take && s1_item.is_last) begin
      out_valid_nxt = 1'b1;
      out_match_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      eq_r        <= 1'b1;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (s1_item.is_last) begin
          pos_r   <= '0;
          eq_r    <= 1'b1;
          found_r <= 1'b0;
        end else begin
          pos_r   <= pos_nxt;
          eq_r    <= eq_nxt;
          found_r <= found_nxt;
        end
      end
    end
  end

  // window contents are only read once position covers them
  always_ff @(posedge clk) begin
    if (take && !s1_item.is_empty) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window_r[j] <= win_new[j];
      end
    end
    out_match_r <= out_match_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_match = out_match_r;

endmodule

`default_nettype wire

>>> sv/string_compare_match.sv
// string_compare_match: streamed byte string vs. configured pattern
// result path: the last byte is captured in the input register when accepted,
//   then its compare result is written to the result register with out_valid
// throughput: one byte per cycle, set by the combinational window compare;
//   a last byte waits only while an earlier result is held by out_ready low
// reset: synchronous active-low rst_n clears valid flags, config registers and string state
// ----------------------------------------------------------------------------
// string_compare_match
// Equals / not-equals / contains compare of a byte stream with a pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module string_compare_match
  import scm_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_char_byte,
  input  wire logic              in_is_last,
  input  wire logic              in_is_empty,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_match,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  logic  take;

  scm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register: refills in the same cycle the core takes its item
  assign in_ready = ~s1_valid_r | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.char_byte <= in_char_byte;
      s1_item_r.is_last   <= in_is_last;
      s1_item_r.is_empty  <= in_is_empty;
    end
  end

  scm_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid_r),
    .s1_item   (s1_item_r),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_match (out_match)
  );

`ifndef SYNTHESIS
  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> s1_valid_r)
    else $error("core took an item from an empty input register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_item_r.is_last) |=> out_valid)
    else $error("last byte did not produce a result");

  a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("stalled request in input register changed");
`endif

endmodule

`default_nettype wire

>>> tb/match_sb_pkg.sv
// ----------------------------------------------------------------------------
// match_sb_pkg
// Pattern-match predictor and result scoreboard for the string compare block.
// ----------------------------------------------------------------------------
package match_sb_pkg;
  import scm_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MODE_EQUALS     = 2'd0,
    MODE_NOT_EQUALS = 2'd1,
    MODE_CONTAINS   = 2'd2,
    MODE_RESERVED   = 2'd3
  } cmp_mode_t;

  class match_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  pattern_len;
    logic [DATA_W-1:0] pattern_low;
    logic [DATA_W-1:0] pattern_high;

    logic [BYTE_W-1:0] window [PAT_BYTES];
    logic [POS_W-1:0]  position;
    bit                equal_so_far;
    bit                found;

    bit match_q[$];
    int errors;

    function new();
      mode         = '0;
      pattern_len  = '0;
      pattern_low  = '0;
      pattern_high = '0;
      errors       = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (window[i]) window[i] = '0;
      position     = '0;
      equal_so_far = 1'b1;
      found        = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_MODE:         mode         = value[MODE_W-1:0];
        REG_PATTERN_LEN:  pattern_len  = value[LEN_W-1:0];
        REG_PATTERN_LOW:  pattern_low  = value;
        REG_PATTERN_HIGH: pattern_high = value;
        default: ;
      endcase
    endfunction

    function logic [BYTE_W-1:0] pattern_byte(int i);
      logic [DATA_W-1:0] word;
      word = (i < 8) ? pattern_low : pattern_high;
      return word[(i % 8) * BYTE_W +: BYTE_W];
    endfunction

    function void note_request(logic [BYTE_W-1:0] b, bit last, bit empty);
      int len;
      bit hit;
      bit res;
      len = (pattern_len > PAT_BYTES) ? PAT_BYTES : int'(pattern_len);
      if (!empty) begin
        if (!(position < len && b == pattern_byte(int'(position)))) equal_so_far = 1'b0;
        for (int i = 0; i < PAT_BYTES - 1; i++) window[i] = window[i+1];
        window[PAT_BYTES-1] = b;
        if (position != POS_MAX) position++;
        // newest len bytes of the window against the whole pattern
        if (position >= len) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++)
            if (window[PAT_BYTES-len+i] != pattern_byte(i)) hit = 1'b0;
          if (hit) found = 1'b1;
        end
      end
      if (last) begin
        if (mode[MODE_CONTAINS_BIT]) begin
          res = (len == 0) || found;
        end else begin
          res = equal_so_far && (position == len);
          if (mode[MODE_INVERT_BIT]) res = !res;
        end
        match_q.push_back(res);
        clear_string();
      end
    endfunction

    function void check_result(logic actual, longint unsigned stamp);
      bit exp_match;
      if (match_q.size() == 0) begin
        errors++;
        $display("%0d ns: result with no request waiting, expected none actual %0b",
                 stamp, actual);
        return;
      end
      exp_match = match_q.pop_front();
      if (actual !== exp_match) begin
        errors++;
        $display("%0d ns: match mismatch, expected %0b actual %0b", stamp, exp_match, actual);
      end
    endfunction

    function int outstanding();
      return match_q.size();
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams strings against configured patterns in all compare modes, with
// random stalls on both channels, and checks every match bit as it arrives.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scm_pkg::*;
  import match_sb_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET    = 650;
  localparam int DRAIN_CYCLES   = 8;

  bit clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_char_byte;
  logic              in_is_last;
  logic              in_is_empty;
  logic              out_valid;
  logic              out_ready;
  logic              out_match;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  match_scoreboard sb = new();

  int idle_cycles = 0;
  int items_sent  = 0;
  bit quiet       = 1'b0;

  // pattern as currently programmed, used to shape the strings
  logic [BYTE_W-1:0] pat_bytes [PAT_BYTES];
  int                pat_len = 0;

  string_compare_match dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_char_byte, .in_is_last, .in_is_empty,
    .out_valid, .out_ready, .out_match,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_char_byte, in_is_last, in_is_empty);
      if (out_valid && out_ready) sb.check_result(out_match, $time);
      if (psel && penable && pwrite && pready)
        sb.write_reg(reg_idx_t'(paddr[ADDR_W-1:3]), pwdata);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    int r;
    int hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
          hold = $urandom_range(1, 12);
        end else if (r < 93) begin
          out_ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(15, 40);
        end
        repeat (hold) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    if (pat_len > 0 && $urandom_range(0, 1) == 1)
      return pat_bytes[$urandom_range(0, pat_len - 1)];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DATA_W-1:0] two_letter_word();
    logic [DATA_W-1:0] w;
    for (int i = 0; i < 8; i++) w[i*BYTE_W +: BYTE_W] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
    return w;
  endfunction

  function automatic byte_q_t make_string();
    byte_q_t s;
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      for (int i = 0; i < pat_len; i++) s.push_back(pat_bytes[i]);
    end else if (kind < 55) begin
      // near miss: one bit flipped, one byte short or one byte long
      for (int i = 0; i < pat_len; i++) s.push_back(pat_bytes[i]);
      k = $urandom_range(0, 2);
      if (k == 0 && s.size() > 0) begin
        k = $urandom_range(0, s.size() - 1);
        s[k] = s[k] ^ (8'h01 << $urandom_range(0, 7));
      end else if (k == 1 && s.size() > 0) begin
        void'(s.pop_back());
      end else begin
        s.push_back(rand_byte());
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(0, 6)) s.push_back(rand_byte());
      for (int i = 0; i < pat_len; i++) s.push_back(pat_bytes[i]);
      repeat ($urandom_range(0, 6)) s.push_back(rand_byte());
    end else if (kind < 95) begin
      repeat ($urandom_range(0, 10)) s.push_back(rand_byte());
    end else begin
      // longer than the window, and at times long enough to saturate the position count
      repeat ($urandom_range(17, 40)) s.push_back(rand_byte());
    end
    return s;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic last, input logic empty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    in_is_last   <= last;
    in_is_empty  <= empty;
    do @(posedge clk); while (!in_ready);
    if (last || !empty) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input byte_q_t s, input bit noisy);
    bit tail_empty;
    tail_empty = noisy && ($urandom_range(0, 7) == 0);
    if (s.size() == 0) begin
      send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    foreach (s[i]) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_item(s[i], (i == s.size() - 1) && !tail_empty, 1'b0);
    end
    if (tail_empty) send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // drop valid and wait out every pending result plus pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic configure(input cmp_mode_t m, input logic [LEN_W-1:0] len,
                           input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    settle();
    apb_write(REG_MODE, DATA_W'(m));
    apb_write(REG_PATTERN_LEN, DATA_W'(len));
    apb_write(REG_PATTERN_LOW, lo);
    apb_write(REG_PATTERN_HIGH, hi);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pat_len = (len > PAT_BYTES) ? PAT_BYTES : int'(len);
    for (int i = 0; i < 8; i++) begin
      pat_bytes[i]   = lo[i*BYTE_W +: BYTE_W];
      pat_bytes[i+8] = hi[i*BYTE_W +: BYTE_W];
    end
  endtask

  initial begin
    byte_q_t           s;
    cmp_mode_t         m;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int                target;
    int                phase;
    int                r;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_byte = '0;
    in_is_last   = 1'b0;
    in_is_empty  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    foreach (pat_bytes[i]) pat_bytes[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: equals against an empty pattern
    send_item(8'hA5, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);

    configure(MODE_EQUALS, 5'd4, 64'hFFFF_FFFF_FF41_FF00, '0);
    s = {8'h00, 8'hFF, 8'h41, 8'hFF};
    send_string(s, 1'b0);
    // empty requests mid-string and as the closing request
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h41, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    s = {8'h00, 8'hFF, 8'h41};
    send_string(s, 1'b0);

    configure(MODE_NOT_EQUALS, 5'd4, 64'hFFFF_FFFF_FF41_FF00, '0);
    s = {8'h00, 8'hFF, 8'h40, 8'hFF};
    send_string(s, 1'b0);

    configure(MODE_CONTAINS, 5'd2, 64'h0000_0000_0000_41FF, '0);
    s = {8'h00, 8'hFF, 8'h41, 8'h00};
    send_string(s, 1'b0);

    configure(MODE_RESERVED, 5'd0, '1, '1);
    send_item(8'h00, 1'b1, 1'b1);

    target = items_sent + ITEM_TARGET;
    phase  = 0;
    while (items_sent < target) begin
      case (phase)
        0: begin
          m = MODE_EQUALS;   len = 5'd16; lo = '1; hi = '1;
        end
        1: begin
          m = MODE_NOT_EQUALS; len = 5'd0; lo = '0; hi = '0;
        end
        2: begin
          m = MODE_CONTAINS; len = 5'd31; lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
        end
        3: begin
          m = MODE_RESERVED; len = 5'd17; lo = two_letter_word(); hi = two_letter_word();
        end
        default: begin
          m = cmp_mode_t'($urandom_range(0, 3));
          r = $urandom_range(0, 7);
          if (r == 0)      len = 5'd0;
          else if (r == 1) len = 5'd16;
          else if (r == 2) len = LEN_W'($urandom_range(17, 31));
          else             len = LEN_W'($urandom_range(1, 15));
          r = $urandom_range(0, 5);
          if (r == 0) begin
            lo = '0; hi = '0;
          end else if (r == 1) begin
            lo = '1; hi = '1;
          end else if (r < 4) begin
            // two-letter alphabet gives overlapping partial matches
            lo = two_letter_word(); hi = two_letter_word();
          end else begin
            lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
          end
        end
      endcase
      configure(m, len, lo, hi);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 14)) send_string(make_string(), 1'b1);
      phase++;
    end

    settle();
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
